// ----- hw/rtl/mrss_pkg.sv -----
// Shared types and constants for the missing/repeating value finder.
// No dependencies; imported by every module of the block.
package mrss_pkg;

  localparam logic [15:0] MRSS_MAX_N = 16'd65535;

  localparam int unsigned DIV_W = 50;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] sum;
    logic [47:0] sq_sum;
    logic        overlong;
  } acc_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_res_t;

endpackage

// ----- hw/rtl/mrss_accum.sv -----
// Running count, sum and sum of squares of the incoming words.
// Depends on mrss_pkg.
module mrss_accum
  import mrss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        clr,
  input  logic [15:0] value,
  output acc_t        acc
);

  logic [31:0] square;

  assign square = {16'b0, value} * {16'b0, value};

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      acc <= '0;
    end else if (en) begin
      if (acc.count >= MRSS_MAX_N) begin
        acc.overlong <= 1'b1;
      end else begin
        acc.count <= acc.count + 16'd1;
      end
      acc.sum    <= acc.sum + {16'b0, value};
      acc.sq_sum <= acc.sq_sum + {16'b0, square};
    end
  end

endmodule

// ----- hw/rtl/mrss_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on mrss_pkg.
module mrss_div
  import mrss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_res_t res
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   sh;
  logic [DIV_W+1:0] df;

  assign sh = {res.rem, res.quo[DIV_W-1]};
  assign df = {1'b0, sh} - {2'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      res.busy <= 1'b0;
      res.done <= 1'b0;
      cnt      <= '0;
    end else begin
      res.done <= 1'b0;
      if (req.start) begin
        res.busy <= 1'b1;
        cnt      <= CNT_W'(DIV_W);
        res.quo  <= req.dividend;
        res.rem  <= '0;
        dsr      <= req.divisor;
      end else if (res.busy) begin
        if (!df[DIV_W+1]) begin
          res.rem <= df[DIV_W-1:0];
        end else begin
          res.rem <= sh[DIV_W-1:0];
        end
        res.quo <= {res.quo[DIV_W-2:0], ~df[DIV_W+1]};
        cnt     <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          res.busy <= 1'b0;
          res.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/missing_repeating_sum_squares.sv -----
// Missing/repeating value finder: words that are not last are taken one per cycle.
// A last word stalls the input until its result word is loaded into the output register.
// Most of that is a pass of the bit-serial divider, skipped when the sums rule out an
// answer before dividing, as is the last solve step when the division is inexact or
// d1 + d2/d1 is odd. An unaccepted result in the output register lengthens the stall.
// Synchronous reset clears the sums, the sequencer and the output valid. Needs mrss_pkg.
module missing_repeating_sum_squares
  import mrss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] repeating, [31:16] missing
  output logic        m_tuser    // [0] valid_res
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_D2,
    S_DIVS, S_DIVW, S_SOL2, S_SOL3, S_OUT
  } state_t;

  state_t state;

  acc_t     acc;
  div_req_t dreq;
  div_res_t dres;
  logic     acc_clr;
  logic     out_free;

  logic [31:0]        sn_r;
  logic [15:0]        n3_r;
  logic [31:0]        ab_r;
  logic [16:0]        fc_r;
  logic [47:0]        s2n_r;
  logic signed [33:0] d1_r;
  logic signed [49:0] d2_r;
  logic signed [50:0] total_r;
  logic signed [51:0] x_r;
  logic signed [52:0] y_r;
  logic               ok_r;

  logic [16:0]        n_p1;
  logic [16:0]        two_n1;
  logic [32:0]        nn1;
  logic [33:0]        n3_prod;
  logic [16:0]        n3x3;
  logic [15:0]        n_mod3;
  logic [16:0]        fa;
  logic [16:0]        fb;
  logic [16:0]        fc;
  logic [33:0]        ab;
  logic [48:0]        prod;
  logic signed [33:0] d1_next;
  logic signed [49:0] d2_next;
  logic [33:0]        abs_d1;
  logic [49:0]        abs_d2;
  logic               q_neg;
  logic signed [50:0] q_s;
  logic signed [51:0] twice;
  logic signed [52:0] x_ext;
  logic signed [52:0] n_s;
  logic               in_range;
  logic               res_ok;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign acc_clr  = (state == S_OUT) && out_free;

  mrss_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .en    (s_tvalid && s_tready),
    .clr   (acc_clr),
    .value (s_tdata),
    .acc   (acc)
  );

  mrss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .res (dres)
  );

  always_comb begin
    n_p1     = {1'b0, acc.count} + 17'd1;
    two_n1   = {acc.count, 1'b1};
    nn1      = {17'b0, acc.count} * {16'b0, n_p1};
    // floor(n/3) by reciprocal, exact for n below 2^17
    n3_prod  = {18'b0, acc.count} * 34'd43691;
    n3x3     = {n3_r, 1'b0} + {1'b0, n3_r};
    n_mod3   = acc.count - n3x3[15:0];
    // take the factor of 3 out of whichever of n, n+1, 2n+1 holds it
    fa = {1'b0, acc.count};
    fb = n_p1;
    fc = two_n1;
    unique case (n_mod3)
      16'd0:   fa = {1'b0, n3_r};
      16'd1:   fc = {n3_r, 1'b1};
      default: fb = {1'b0, n3_r} + 17'd1;
    endcase
    ab       = {17'b0, fa} * {17'b0, fb};
    prod     = {17'b0, ab_r} * {32'b0, fc_r};
    d1_next  = $signed({2'b0, acc.sum}) - $signed({2'b0, sn_r});
    d2_next  = $signed({2'b0, acc.sq_sum}) - $signed({2'b0, s2n_r});
    abs_d1   = d1_r[33] ? 34'(-d1_r) : 34'(d1_r);
    abs_d2   = d2_r[49] ? 50'(-d2_r) : 50'(d2_r);
    q_neg    = d1_r[33] ^ d2_r[49];
    q_s      = $signed({1'b0, dres.quo});
    twice    = $signed({{18{d1_r[33]}}, d1_r}) + $signed({total_r[50], total_r});
    x_ext    = $signed({x_r[51], x_r});
    n_s      = $signed({37'b0, acc.count});
    in_range = (x_ext > 53'sd0) && (x_ext <= n_s) && (y_r > 53'sd0) && (y_r <= n_s);
    res_ok   = ok_r && in_range;

    dreq = '0;
    unique case (state)
      S_DIVS: begin
        dreq.start    = 1'b1;
        dreq.dividend = abs_d2;
        dreq.divisor  = {16'b0, abs_d1};
      end
      default: dreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      ok_r     <= 1'b0;
    end else begin
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tlast) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          sn_r  <= nn1[32:1];
          n3_r  <= n3_prod[32:17];
          ok_r  <= 1'b1;
          state <= S_MUL2;
        end
        S_MUL2: begin
          d1_r  <= d1_next;
          ab_r  <= ab[32:1];
          fc_r  <= fc;
          state <= S_MUL3;
        end
        S_MUL3: begin
          s2n_r <= prod[47:0];
          state <= S_D2;
        end
        S_D2: begin
          d2_r <= d2_next;
          if (acc.overlong || d1_r == 34'sd0) begin
            ok_r  <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_DIVS;
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (dres.done) begin
            total_r <= q_neg ? -q_s : q_s;
            if (dres.rem != '0) begin
              ok_r <= 1'b0;
            end
            state <= S_SOL2;
          end
        end
        S_SOL2: begin
          x_r <= twice >>> 1;
          if (!ok_r || twice[0]) begin
            ok_r  <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_SOL3;
          end
        end
        S_SOL3: begin
          y_r   <= $signed({{2{total_r[50]}}, total_r}) - x_ext;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_ok ? {y_r[15:0], x_r[15:0]} : 32'd0;
            m_tuser  <= res_ok;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_take_while_dividing: assert property (@(posedge clk) disable iff (rst)
    dres.busy |-> !s_tready)
    else $error("input taken while divider busy");

  a_last_stalls_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input not stalled after last word");

  a_valid_result_sane: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[15:0] != 16'd0) && (m_tdata[31:16] != 16'd0)
      && (m_tdata[15:0] != m_tdata[31:16]))
    else $error("valid result out of range");

endmodule

// ----- bench/missing_repeating_sum_squares_test.sv -----
// Testbench for missing_repeating_sum_squares: streams value sequences, predicts
// the repeating/missing pair of each and checks every result word.
// Depends on mrss_pkg and the missing_repeating_sum_squares RTL.
module missing_repeating_sum_squares_test
  import mrss_pkg::*;
();

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [15:0] repeating;
    logic [15:0] missing;
    logic        ok;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] value
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [15:0] repeating, [31:16] missing
  logic        m_tuser;        // [0] valid_res

  word_t   pending_words[$];
  answer_t pending_answers[$];
  int      fail_count = 0;
  int      cycle_count = 0;

  // predictor state
  logic [15:0] elem_count = '0;
  logic [31:0] val_sum = '0;
  logic [47:0] sq_sum = '0;
  bit          too_long = 1'b0;

  missing_repeating_sum_squares u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // quiet stretch with no idling on either side
  function automatic bit idle_now();
    if (cycle_count >= 2000 && cycle_count < 5000) return 1'b0;
    return $urandom_range(0, 99) < 18;
  endfunction

  function automatic void fold_word(input word_t w, output bit done, output answer_t a);
    longint n, sn, s2n, d1, d2, total, twice, x, y, tsum, tsq;
    bit ok;
    done = 1'b0;
    a = '0;
    if (elem_count == MRSS_MAX_N) too_long = 1'b1;
    else elem_count++;
    val_sum = val_sum + 32'(w.value);
    sq_sum = sq_sum + 48'(w.value) * 48'(w.value);
    if (!w.last) return;
    done = 1'b1;
    n = longint'(elem_count);
    tsum = longint'(val_sum);
    tsq = longint'(sq_sum);
    sn = n * (n + 1) / 2;
    s2n = n * (n + 1) * (2 * n + 1) / 6;
    d1 = tsum - sn;
    d2 = tsq - s2n;
    ok = !too_long;
    x = 0;
    y = 0;
    if (ok && d1 == 0) ok = 1'b0;
    if (ok && (d2 % d1) != 0) ok = 1'b0;
    if (ok) begin
      total = d2 / d1;
      twice = d1 + total;
      if ((twice % 2) != 0) begin
        ok = 1'b0;
      end else begin
        x = twice / 2;
        y = total - x;
        if (x < 1 || x > n || y < 1 || y > n) ok = 1'b0;
      end
    end
    if (ok) begin
      a.repeating = x[15:0];
      a.missing = y[15:0];
      a.ok = 1'b1;
    end
    elem_count = '0;
    val_sum = '0;
    sq_sum = '0;
    too_long = 1'b0;
  endfunction

  always @(posedge clk) begin : drive
    word_t   w;
    answer_t a;
    bit      done;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        w.value = s_tdata;
        w.last = s_tlast;
        fold_word(w, done, a);
        if (done) pending_answers.push_back(a);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && !idle_now()) begin
          w = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= w.value;
          s_tlast <= w.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !idle_now();
  end

  always @(posedge clk) begin : check
    answer_t a;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        $error("result word with none expected: data %h user %b", m_tdata, m_tuser);
        fail_count++;
      end else begin
        a = pending_answers.pop_front();
        if (m_tdata[15:0] !== a.repeating) begin
          $error("repeating: expected %0d, got %0d", a.repeating, m_tdata[15:0]);
          fail_count++;
        end
        if (m_tdata[31:16] !== a.missing) begin
          $error("missing: expected %0d, got %0d", a.missing, m_tdata[31:16]);
          fail_count++;
        end
        if (m_tuser !== a.ok) begin
          $error("valid_res: expected %0d, got %0d", a.ok, m_tuser);
          fail_count++;
        end
      end
    end
  end

  task automatic push_seq(input int vals[$]);
    word_t w;
    foreach (vals[i]) begin
      w.value = 16'(vals[i]);
      w.last = (i == vals.size() - 1);
      pending_words.push_back(w);
    end
  endtask

  // permutation of 1..n with mis replaced by rep
  task automatic push_perm(input int n, input int rep, input int mis);
    int vals[$];
    int j, t;
    for (int i = 1; i <= n; i++) vals.push_back(i == mis ? rep : i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = vals[i];
      vals[i] = vals[j];
      vals[j] = t;
    end
    push_seq(vals);
  endtask

  task automatic push_noise(input int len, input int top);
    int vals[$];
    for (int i = 0; i < len; i++) vals.push_back($urandom_range(0, top));
    push_seq(vals);
  endtask

  task automatic push_good(input int n);
    int rep, mis;
    mis = $urandom_range(1, n);
    do rep = $urandom_range(1, n); while (rep == mis);
    push_perm(n, rep, mis);
  endtask

  initial begin
    int items, seqs, n, pick;

    // directed
    push_seq('{1});
    push_seq('{0});
    push_seq('{65535});
    push_seq('{1, 1});
    push_seq('{2, 2});
    push_seq('{1, 2, 3});
    push_seq('{3, 3, 3});
    push_seq('{0, 2, 3});
    push_seq('{0, 0, 4});
    push_seq('{65535, 0, 2});
    push_perm(5, 5, 1);

    // random
    items = 0;
    seqs = 0;
    while (items < 1000 || seqs < 40) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = $urandom_range(2, 30);
        push_good(n);
      end else if (pick < 73) begin
        n = $urandom_range(100, 600);
        push_good(n);
      end else if (pick < 80) begin
        // well-formed but one element disturbed
        n = $urandom_range(2, 20);
        push_good(n);
        pending_words[pending_words.size() - 1 - $urandom_range(0, n - 1)].value =
          16'($urandom_range(0, 65535));
      end else if (pick < 85) begin
        n = $urandom_range(1, 8);
        push_noise(n, n + 2);
      end else begin
        n = $urandom_range(1, 12);
        push_noise(n, 65535);
      end
      items += n;
      seqs++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (pending_words.size() == 0 && !s_tvalid && pending_answers.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

endmodule
